[sv/pps_pkg.sv]
// Shared constants, entry layout and controller/datapath signal groups.
package pps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 8;
  localparam int PRIO_W      = 8;
  localparam int LEFT_W      = 16;
  localparam int WAIT_W      = 5;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_ARRIVE = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [LEFT_W-1:0] left;
  } pps_entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic take;
    logic shift_step;
    logic pop;
    logic load_out;
  } pps_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic arrival;
    logic need_pick;
    logic empty;
    logic scan_end;
    logic shift_end;
  } pps_stat_t;

endpackage

[sv/pps_ctrl.sv]
// Controller state machine: accept, priority scan, queue compaction, result hand-off.
module pps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pps_pkg::pps_stat_t  stat,
  output pps_pkg::pps_cmd_t   ctl
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        ctl.accept = in_valid;
        if (in_valid) begin
          if (!stat.arrival && stat.need_pick && !stat.empty) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          ctl.take   = 1'b1;
          state_next = S_SHIFT;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.shift_end) begin
          ctl.pop    = 1'b1;
          state_next = S_DONE;
        end else begin
          ctl.shift_step = 1'b1;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat accepted while an item is in flight");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> (state == S_SCAN || state == S_SHIFT))
    else $error("scan left without a pick");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped before it was taken");

endmodule

[sv/pps_dp.sv]
// Datapath: running-process registers, ready queue storage, scan and compaction pointers.
module pps_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd,
  input  logic [pps_pkg::ID_W-1:0]           proc_id,
  input  logic [pps_pkg::PRIO_W-1:0]         prio,
  input  logic [pps_pkg::LEFT_W-1:0]         burst,
  input  pps_pkg::pps_cmd_t                  ctl,
  output pps_pkg::pps_stat_t                 stat,
  output logic                               run_valid,
  output logic [pps_pkg::ID_W-1:0]           run_id,
  output logic [pps_pkg::PRIO_W-1:0]         run_prio,
  output logic [pps_pkg::LEFT_W-1:0]         run_left,
  output logic [pps_pkg::WAIT_W-1:0]         waiting,
  output logic                               overflow
);

  pps_pkg::pps_entry_t slots [pps_pkg::QUEUE_DEPTH];

  logic                             cur_valid;
  logic [pps_pkg::ID_W-1:0]         cur_id;
  logic [pps_pkg::PRIO_W-1:0]       cur_prio;
  logic [pps_pkg::LEFT_W-1:0]       cur_left;
  logic [pps_pkg::CNT_W-1:0]        count;
  logic [pps_pkg::CNT_W-1:0]        ptr;
  logic [pps_pkg::IDX_W-1:0]        best_idx;
  pps_pkg::pps_entry_t              best_ent;
  logic                             ovf;

  logic [pps_pkg::CNT_W-1:0]        ptr_plus1;
  logic [pps_pkg::CNT_W-1:0]        ptr_next;
  logic [pps_pkg::CNT_W-1:0]        ptr_next_plus1;
  pps_pkg::pps_entry_t              scan_ent;
  pps_pkg::pps_entry_t              shift_ent;
  pps_pkg::pps_entry_t              push_ent;
  logic                             full;
  logic                             arrive;
  logic                             tick;
  logic                             preempt;
  logic                             do_push;

  assign ptr_plus1 = ptr + pps_pkg::CNT_W'(1);

  assign full    = (count == pps_pkg::CNT_W'(pps_pkg::QUEUE_DEPTH));
  assign arrive  = ctl.accept && (cmd == pps_pkg::CMD_ARRIVE);
  assign tick    = ctl.accept && (cmd == pps_pkg::CMD_TICK);
  assign preempt = cur_valid && (prio > cur_prio);
  assign do_push = arrive && !full;

  // A preempted process goes to the tail; otherwise the arrival does
  always_comb begin
    if (preempt) begin
      push_ent = '{id: cur_id, prio: cur_prio, left: cur_left};
    end else begin
      push_ent = '{id: proc_id, prio: prio, left: burst};
    end
  end

  assign stat.arrival   = (cmd == pps_pkg::CMD_ARRIVE);
  assign stat.need_pick = !cur_valid || (cur_left == '0);
  assign stat.empty     = (count == '0);
  assign stat.scan_end  = (ptr == count);
  assign stat.shift_end = (ptr_plus1 >= count);

  // Restart the scan on a pick, jump to the picked slot, advance while scanning or shifting
  always_comb begin
    ptr_next = ptr;
    if (tick && stat.need_pick && !stat.empty) begin
      ptr_next = '0;
    end
    if (ctl.take) begin
      ptr_next = pps_pkg::CNT_W'(best_idx);
    end
    if (ctl.scan_step || ctl.shift_step) begin
      ptr_next = ptr_plus1;
    end
  end

  assign ptr_next_plus1 = ptr_next + pps_pkg::CNT_W'(1);

  // Read ahead: the slot at the pointer for the scan, the one above it for compaction
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[count[pps_pkg::IDX_W-1:0]] <= push_ent;
    end else if (ctl.shift_step) begin
      slots[ptr[pps_pkg::IDX_W-1:0]] <= shift_ent;
    end
    scan_ent  <= slots[ptr_next[pps_pkg::IDX_W-1:0]];
    shift_ent <= slots[ptr_next_plus1[pps_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_id    <= '0;
      cur_prio  <= '0;
      cur_left  <= '0;
      count     <= '0;
      ptr       <= '0;
      ovf       <= 1'b0;
    end else begin
      ptr <= ptr_next;
      if (ctl.accept) begin
        ovf <= arrive && full;
      end
      if (do_push) begin
        count <= count + pps_pkg::CNT_W'(1);
        if (preempt) begin
          cur_id   <= proc_id;
          cur_prio <= prio;
          cur_left <= burst;
        end
      end
      if (tick) begin
        if (stat.need_pick) begin
          if (stat.empty) begin
            cur_valid <= 1'b0;
            cur_id    <= '0;
            cur_prio  <= '0;
            cur_left  <= '0;
          end
        end else begin
          cur_left <= cur_left - pps_pkg::LEFT_W'(1);
        end
      end
      if (ctl.take) begin
        cur_valid <= 1'b1;
        cur_id    <= best_ent.id;
        cur_prio  <= best_ent.prio;
        cur_left  <= (best_ent.left == '0) ? '0 : best_ent.left - pps_pkg::LEFT_W'(1);
      end
      if (ctl.pop) begin
        count <= count - pps_pkg::CNT_W'(1);
      end
    end
  end

  // Strictly greater keeps the earliest entry among equal priorities
  always_ff @(posedge clk) begin
    if (ctl.scan_step && ((ptr == '0) || (scan_ent.prio > best_ent.prio))) begin
      best_ent <= scan_ent;
      best_idx <= ptr[pps_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      run_valid <= cur_valid;
      run_id    <= cur_id;
      run_prio  <= cur_prio;
      run_left  <= cur_left;
      waiting   <= pps_pkg::WAIT_W'(count);
      overflow  <= ovf;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pps_pkg::CNT_W'(pps_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !cur_valid |-> (cur_id == '0 && cur_prio == '0 && cur_left == '0))
    else $error("running-process fields not cleared while nothing runs");

  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.take |-> (count != '0 && pps_pkg::CNT_W'(best_idx) < count))
    else $error("pick from an empty queue or past its tail");

endmodule

[sv/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler: one running process plus a ready queue of
// QUEUE_DEPTH entries (16) kept in arrival order. Every input beat gives exactly
// one output beat with the state after that item. An arrival, or a tick that only
// counts down the running process (or finds the queue empty), goes from accept
// straight to the result hand-off. For a tick that must pick the next process,
// the controller scans the queue one entry a cycle for the highest priority
// (earliest wins a tie), then closes the gap by moving later entries down one a
// cycle through the single write port of the queue storage. One item is in work at
// a time; in_ready is low from accept until the result is loaded into the output
// register, and a result not yet taken holds the block before hand-off.
module preemptive_priority_scheduler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               cmd,
  input  logic [pps_pkg::ID_W-1:0]           proc_id,
  input  logic [pps_pkg::PRIO_W-1:0]         prio,
  input  logic [pps_pkg::LEFT_W-1:0]         burst,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               run_valid,
  output logic [pps_pkg::ID_W-1:0]           run_id,
  output logic [pps_pkg::PRIO_W-1:0]         run_prio,
  output logic [pps_pkg::LEFT_W-1:0]         run_left,
  output logic [pps_pkg::WAIT_W-1:0]         waiting,
  output logic                               overflow
);

  pps_pkg::pps_cmd_t  ctl;
  pps_pkg::pps_stat_t stat;

  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  pps_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .proc_id   (proc_id),
    .prio      (prio),
    .burst     (burst),
    .ctl       (ctl),
    .stat      (stat),
    .run_valid (run_valid),
    .run_id    (run_id),
    .run_prio  (run_prio),
    .run_left  (run_left),
    .waiting   (waiting),
    .overflow  (overflow)
  );

endmodule

[dv/preemptive_priority_scheduler_tb.sv]
// Self-checking testbench for the preemptive priority scheduler.
module preemptive_priority_scheduler_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 2 * pps_pkg::QUEUE_DEPTH + 8;
  localparam int MAX_GAP       = 13;

  typedef struct packed {
    logic                       run_valid;
    logic [pps_pkg::ID_W-1:0]   run_id;
    logic [pps_pkg::PRIO_W-1:0] run_prio;
    logic [pps_pkg::LEFT_W-1:0] run_left;
    logic [pps_pkg::WAIT_W-1:0] waiting;
    logic                       overflow;
  } sched_view_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic                       cmd       = pps_pkg::CMD_TICK;
  logic [pps_pkg::ID_W-1:0]   proc_id   = '0;
  logic [pps_pkg::PRIO_W-1:0] prio      = '0;
  logic [pps_pkg::LEFT_W-1:0] burst     = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       run_valid;
  logic [pps_pkg::ID_W-1:0]   run_id;
  logic [pps_pkg::PRIO_W-1:0] run_prio;
  logic [pps_pkg::LEFT_W-1:0] run_left;
  logic [pps_pkg::WAIT_W-1:0] waiting;
  logic                       overflow;

  // scheduler state as the testbench sees it
  logic                 active_on = 1'b0;
  pps_pkg::pps_entry_t  active    = '0;
  pps_pkg::pps_entry_t  ready_q [pps_pkg::QUEUE_DEPTH];
  int                   ready_cnt = 0;

  sched_view_t expected_views[$];
  int          err_count   = 0;
  int          n_checked   = 0;
  int          n_sent      = 0;
  int          n_picks     = 0;
  int          n_preempts  = 0;
  int          n_drops     = 0;
  int          cycle_count = 0;
  int          ready_wait  = 0;
  bit          no_idle     = 1'b0;

  always #1 clk = ~clk;

  preemptive_priority_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .proc_id   (proc_id),
    .prio      (prio),
    .burst     (burst),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .run_valid (run_valid),
    .run_id    (run_id),
    .run_prio  (run_prio),
    .run_left  (run_left),
    .waiting   (waiting),
    .overflow  (overflow)
  );

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void enqueue_ready(pps_pkg::pps_entry_t e);
    ready_q[ready_cnt] = e;
    ready_cnt++;
  endfunction

  // Apply one item to the local scheduler state and return the view after it.
  function automatic sched_view_t schedule_item(logic c, logic [pps_pkg::ID_W-1:0] pid,
                                                logic [pps_pkg::PRIO_W-1:0] pr,
                                                logic [pps_pkg::LEFT_W-1:0] bu);
    sched_view_t v;
    int          best;
    logic        dropped;
    dropped = 1'b0;
    if (c == pps_pkg::CMD_ARRIVE) begin
      if (ready_cnt >= pps_pkg::QUEUE_DEPTH) begin
        dropped = 1'b1;
        n_drops++;
      end else if (active_on && pr > active.prio) begin
        enqueue_ready(active);
        active = '{id: pid, prio: pr, left: bu};
        n_preempts++;
      end else begin
        enqueue_ready('{id: pid, prio: pr, left: bu});
      end
    end else begin
      if (!active_on || active.left == '0) begin
        if (ready_cnt == 0) begin
          active_on = 1'b0;
          active    = '0;
        end else begin
          // strict compare keeps the earliest entry on a tie
          best = 0;
          for (int i = 1; i < ready_cnt; i++)
            if (ready_q[i].prio > ready_q[best].prio) best = i;
          active_on = 1'b1;
          active    = ready_q[best];
          for (int i = best; i < ready_cnt - 1; i++) ready_q[i] = ready_q[i + 1];
          ready_cnt--;
          n_picks++;
        end
      end
      if (active_on && active.left != '0) active.left = active.left - pps_pkg::LEFT_W'(1);
    end
    v.run_valid = active_on;
    v.run_id    = active_on ? active.id : '0;
    v.run_prio  = active_on ? active.prio : '0;
    v.run_left  = active_on ? active.left : '0;
    v.waiting   = ready_cnt[pps_pkg::WAIT_W-1:0];
    v.overflow  = dropped;
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR cycle %0d: %s (got 0x%0h, want 0x%0h)", cycle_count, what, got, want);
    err_count++;
  endtask

  // Drive one beat and hold it until accepted; call only at a rising edge.
  task automatic send_item(logic c, logic [pps_pkg::ID_W-1:0] pid,
                           logic [pps_pkg::PRIO_W-1:0] pr,
                           logic [pps_pkg::LEFT_W-1:0] bu);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    proc_id  <= pid;
    prio     <= pr;
    burst    <= bu;
    do @(posedge clk); while (!in_ready);
    expected_views.push_back(schedule_item(c, pid, pr, bu));
    n_sent++;
  endtask

  task automatic send_tick();
    send_item(pps_pkg::CMD_TICK, pps_pkg::ID_W'($urandom_range(0, 255)),
              pps_pkg::PRIO_W'($urandom_range(0, 255)),
              pps_pkg::LEFT_W'($urandom_range(0, 65535)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_views.size() != 0);
  endtask

  // Mostly few priority levels so ties and equal-priority arrivals are common.
  function automatic logic [pps_pkg::PRIO_W-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return pps_pkg::PRIO_W'($urandom_range(0, 3));
    if (r < 8) return (r == 6) ? 8'hFF : 8'h00;
    return pps_pkg::PRIO_W'($urandom_range(0, 255));
  endfunction

  // Short bursts let processes finish so the queue keeps turning over.
  function automatic logic [pps_pkg::LEFT_W-1:0] pick_burst();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return pps_pkg::LEFT_W'($urandom_range(0, 5));
    if (r < 95) return pps_pkg::LEFT_W'($urandom_range(6, 40));
    return pps_pkg::LEFT_W'($urandom_range(0, 65535));
  endfunction

  task automatic random_items(int n, int arrive_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < arrive_pct)
        send_item(pps_pkg::CMD_ARRIVE, pps_pkg::ID_W'($urandom_range(0, 255)),
                  pick_prio(), pick_burst());
      else
        send_tick();
    end
  endtask

  task automatic test_directed_cases();
    send_tick();                                            // empty queue, nothing runs
    send_item(pps_pkg::CMD_ARRIVE, 8'h00, 8'h00, 16'h0000); // arrival while idle is queued
    send_tick();                                            // zero burst runs with nothing left
    send_tick();                                            // replaced, queue empty -> idle
    send_item(pps_pkg::CMD_ARRIVE, 8'h01, 8'h10, 16'hFFFF);
    send_tick();
    send_item(pps_pkg::CMD_ARRIVE, 8'h02, 8'h10, 16'h0003); // equal priority, no preempt
    send_item(pps_pkg::CMD_ARRIVE, 8'hFF, 8'hFF, 16'h0001); // preempts
    send_item(pps_pkg::CMD_ARRIVE, 8'h03, 8'hFF, 16'h0002);
    send_item(pps_pkg::CMD_ARRIVE, 8'h04, 8'h00, 16'h0000);
    send_tick();
    send_tick();                                            // picks the only queued 0xFF entry
    send_tick();
    send_tick();
    send_tick();                                            // counts down the earliest 0x10 entry, which won the tie
    send_item(pps_pkg::CMD_ARRIVE, 8'hAA, 8'h55, 16'hAAAA);
    send_item(pps_pkg::CMD_ARRIVE, 8'h55, 8'hAA, 16'h5555);
    repeat (4) send_tick();
  endtask

  task automatic test_queue_full();
    while (ready_cnt < pps_pkg::QUEUE_DEPTH)
      send_item(pps_pkg::CMD_ARRIVE, pps_pkg::ID_W'($urandom_range(0, 255)),
                pps_pkg::PRIO_W'($urandom_range(0, 3)),
                pps_pkg::LEFT_W'($urandom_range(0, 4)));
    // full queue: drop a would-be preemption and a plain arrival
    send_item(pps_pkg::CMD_ARRIVE, pps_pkg::ID_W'($urandom_range(0, 255)), 8'hFF,
              pps_pkg::LEFT_W'($urandom_range(0, 65535)));
    send_item(pps_pkg::CMD_ARRIVE, pps_pkg::ID_W'($urandom_range(0, 255)), 8'h00,
              pps_pkg::LEFT_W'($urandom_range(0, 65535)));
    repeat (30) begin
      if ($urandom_range(0, 3) == 0)
        send_item(pps_pkg::CMD_ARRIVE, pps_pkg::ID_W'($urandom_range(0, 255)),
                  pick_prio(), pps_pkg::LEFT_W'($urandom_range(0, 3)));
      else
        send_tick();
    end
  endtask

  task automatic test_mixed_traffic();
    for (int chunk = 0; chunk < 6; chunk++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      random_items(50, 40 + 5 * chunk);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    random_items(40, 55);
    wait_drained();
    random_items(20, 50);
    no_idle = 1'b0;
  endtask

  task automatic test_noise();
    repeat (80)
      send_item(1'($urandom_range(0, 1)), pps_pkg::ID_W'($urandom_range(0, 255)),
                pps_pkg::PRIO_W'($urandom_range(0, 255)),
                pps_pkg::LEFT_W'($urandom_range(0, 65535)));
  endtask

  // result side: random stall after every beat taken
  always @(posedge clk) begin : result_ready
    int w;
    if (rst) begin
      out_ready  <= 1'b0;
      ready_wait <= 0;
    end else if (out_valid && out_ready) begin
      w = draw_gap();
      ready_wait <= w;
      out_ready  <= (w == 0);
    end else if (ready_wait > 0) begin
      ready_wait <= ready_wait - 1;
      out_ready  <= (ready_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    sched_view_t want;
    if (!rst && out_valid && out_ready) begin
      n_checked++;
      if (expected_views.size() == 0) begin
        report_mismatch("result beat with nothing expected", 32'(run_id), 32'd0);
      end else begin
        want = expected_views.pop_front();
        if (run_valid !== want.run_valid)
          report_mismatch("run_valid", 32'(run_valid), 32'(want.run_valid));
        if (run_id !== want.run_id)
          report_mismatch("run_id", 32'(run_id), 32'(want.run_id));
        if (run_prio !== want.run_prio)
          report_mismatch("run_prio", 32'(run_prio), 32'(want.run_prio));
        if (run_left !== want.run_left)
          report_mismatch("run_left", 32'(run_left), 32'(want.run_left));
        if (waiting !== want.waiting)
          report_mismatch("waiting", 32'(waiting), 32'(want.waiting));
        if (overflow !== want.overflow)
          report_mismatch("overflow", 32'(overflow), 32'(want.overflow));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, expected_views.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_queue_full();
    test_mixed_traffic();
    test_back_to_back();
    test_noise();
    in_valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_views.size() != 0)
      report_mismatch("expected results never arrived", 32'd0, expected_views.size());
    $display("covered %0d items, %0d results checked: %0d picks, %0d preemptions, %0d drops",
             n_sent, n_checked, n_picks, n_preempts, n_drops);
    $display("%0d mismatches in %0d cycles", err_count, cycle_count);
    if (err_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
